// File: rtl/bbc_pkg.sv
// shared constants, codes and controller/datapath interface types for the band-pass cascade
package bbc_pkg;

  // defaults for the top-level parameters
  localparam int unsigned SAMPLE_BITS_DEF    = 24;
  localparam int unsigned COEF_FRAC_BITS_DEF = 28;

  // fixed widths
  localparam int unsigned COEF_BITS    = 32;
  localparam int unsigned DELAY_BITS   = 40;
  // w0 + 2*w1 + w2 needs two guard bits
  localparam int unsigned SUM_BITS     = DELAY_BITS + 2;
  // wide operand is split into an unsigned low half and a signed high half
  localparam int unsigned SPLIT_BITS   = SUM_BITS / 2;
  localparam int unsigned MUL_B_BITS   = SPLIT_BITS + 1;
  localparam int unsigned PROD_BITS    = COEF_BITS + MUL_B_BITS;
  localparam int unsigned ACC_BITS     = COEF_BITS + SUM_BITS + 2;
  localparam int unsigned CFG_IDX_BITS = 3;

  // configuration register indices
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HIGH_GAIN         = 3'd0,
    REG_HIGH_FEEDBACK_ONE = 3'd1,
    REG_HIGH_FEEDBACK_TWO = 3'd2,
    REG_LOW_GAIN          = 3'd3,
    REG_LOW_FEEDBACK_ONE  = 3'd4,
    REG_LOW_FEEDBACK_TWO  = 3'd5
  } cfg_reg_e;

  // multiplier operand pairs
  typedef enum logic [1:0] {
    OP_FB1_D1,
    OP_FB2_D2,
    OP_GAIN_SUM
  } op_sel_e;

  // controller to datapath
  typedef struct packed {
    logic    start;      // capture sample, clear clip flag
    logic    load_acc;   // acc <= x * 2^F + half
    logic    load_half;  // acc <= half
    logic    mul_en;     // issue a product
    op_sel_e op_sel;
    logic    part_hi;    // high half of the wide operand
    logic    sub;        // subtract the product from acc
    logic    sec;        // 0 highpass, 1 lowpass
    logic    take_sum;   // saturate w0, form tap sum, shift delay line
    logic    take_y;     // store highpass output
    logic    load_out;   // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// File: rtl/bbc_datapath.sv
// coefficient registers, delay lines, shared multiply-accumulate and output register
module bbc_datapath #(
  parameter int unsigned SAMPLE_BITS    = bbc_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = bbc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  input  logic        [bbc_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic signed [bbc_pkg::COEF_BITS-1:0]    cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0]           sample_in_i,
  input  bbc_pkg::cmd_t                           cmd_i,
  output bbc_pkg::status_t                        status_o,
  input  logic                                    out_stall_i,
  output logic                                    out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]           sample_out_o,
  output logic                                    clipped_o
);

  localparam int unsigned CW = bbc_pkg::COEF_BITS;
  localparam int unsigned DW = bbc_pkg::DELAY_BITS;
  localparam int unsigned SW = bbc_pkg::SUM_BITS;
  localparam int unsigned AW = bbc_pkg::ACC_BITS;
  localparam int unsigned PW = bbc_pkg::PROD_BITS;
  localparam int unsigned BW = bbc_pkg::MUL_B_BITS;
  localparam int unsigned SP = bbc_pkg::SPLIT_BITS;

  localparam logic [AW-1:0] HALF = {{(AW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [AW-1:0] W_MAX = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [AW-1:0] W_MIN = ~W_MAX;
  localparam logic signed [AW-1:0] Y_MAX = {{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [AW-1:0] Y_MIN = ~Y_MAX;

  // coefficients
  logic signed [CW-1:0] hg_q, hf1_q, hf2_q, lg_q, lf1_q, lf2_q;
  // delay lines
  logic signed [DW-1:0] hd1_q, hd2_q, ld1_q, ld2_q;
  // working registers
  logic signed [SAMPLE_BITS-1:0] x_q, h_q;
  logic signed [SW-1:0]          sum_q;
  logic signed [AW-1:0]          acc_q, acc_d;
  logic signed [PW-1:0]          prod_q;
  logic                          prod_vld_q, prod_hi_q, prod_sub_q;
  logic                          clip_q;
  logic                          out_vld_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_clip_q;

  logic signed [DW-1:0]          d1, d2;
  logic signed [CW-1:0]          coef;
  logic signed [SW-1:0]          wide_val;
  logic signed [BW-1:0]          mul_b;
  logic signed [PW-1:0]          mul_p;
  logic signed [AW-1:0]          term, preload, scaled;
  logic signed [SAMPLE_BITS-1:0] x_src;
  logic signed [DW-1:0]          w0_sat;
  logic                          w0_clip;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          y_clip;
  logic signed [SW-1:0]          w0_ext, d1_x2, d2_ext, sum_d;

  assign d1 = cmd_i.sec ? ld1_q : hd1_q;
  assign d2 = cmd_i.sec ? ld2_q : hd2_q;

  // operand selection
  always_comb begin
    case (cmd_i.op_sel)
      bbc_pkg::OP_FB1_D1: begin
        coef     = cmd_i.sec ? lf1_q : hf1_q;
        wide_val = {{(SW-DW){d1[DW-1]}}, d1};
      end
      bbc_pkg::OP_FB2_D2: begin
        coef     = cmd_i.sec ? lf2_q : hf2_q;
        wide_val = {{(SW-DW){d2[DW-1]}}, d2};
      end
      default: begin
        coef     = cmd_i.sec ? lg_q : hg_q;
        wide_val = sum_q;
      end
    endcase
  end

  // low half unsigned, high half signed
  assign mul_b = cmd_i.part_hi ? {wide_val[SW-1], wide_val[SW-1:SP]}
                               : {1'b0, wide_val[SP-1:0]};
  assign mul_p = coef * mul_b;

  assign term = prod_hi_q ? ({{(AW-PW){prod_q[PW-1]}}, prod_q} <<< SP)
                          : {{(AW-PW){prod_q[PW-1]}}, prod_q};

  assign x_src   = cmd_i.sec ? h_q : x_q;
  assign preload = ({{(AW-SAMPLE_BITS){x_src[SAMPLE_BITS-1]}}, x_src} <<< COEF_FRAC_BITS)
                   + HALF;

  always_comb begin
    if (cmd_i.load_acc) begin
      acc_d = preload;
    end else if (cmd_i.load_half) begin
      acc_d = HALF;
    end else if (prod_vld_q) begin
      acc_d = prod_sub_q ? acc_q - term : acc_q + term;
    end else begin
      acc_d = acc_q;
    end
  end

  // floor shift and saturation
  assign scaled = acc_q >>> COEF_FRAC_BITS;

  always_comb begin
    if (scaled > W_MAX) begin
      w0_sat  = W_MAX[DW-1:0];
      w0_clip = 1'b1;
    end else if (scaled < W_MIN) begin
      w0_sat  = W_MIN[DW-1:0];
      w0_clip = 1'b1;
    end else begin
      w0_sat  = scaled[DW-1:0];
      w0_clip = 1'b0;
    end
  end

  always_comb begin
    if (scaled > Y_MAX) begin
      y_sat  = Y_MAX[SAMPLE_BITS-1:0];
      y_clip = 1'b1;
    end else if (scaled < Y_MIN) begin
      y_sat  = Y_MIN[SAMPLE_BITS-1:0];
      y_clip = 1'b1;
    end else begin
      y_sat  = scaled[SAMPLE_BITS-1:0];
      y_clip = 1'b0;
    end
  end

  // tap sum: highpass w0 - 2*w1 + w2, lowpass w0 + 2*w1 + w2
  assign w0_ext = {{(SW-DW){w0_sat[DW-1]}}, w0_sat};
  assign d1_x2  = {{(SW-DW){d1[DW-1]}}, d1} <<< 1;
  assign d2_ext = {{(SW-DW){d2[DW-1]}}, d2};
  assign sum_d  = cmd_i.sec ? w0_ext + d1_x2 + d2_ext : w0_ext - d1_x2 + d2_ext;

  // configuration, filter state and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hg_q       <= '0;
      hf1_q      <= '0;
      hf2_q      <= '0;
      lg_q       <= '0;
      lf1_q      <= '0;
      lf2_q      <= '0;
      hd1_q      <= '0;
      hd2_q      <= '0;
      ld1_q      <= '0;
      ld2_q      <= '0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (bbc_pkg::cfg_reg_e'(cfg_index_i))
          bbc_pkg::REG_HIGH_GAIN:         hg_q  <= cfg_data_i;
          bbc_pkg::REG_HIGH_FEEDBACK_ONE: hf1_q <= cfg_data_i;
          bbc_pkg::REG_HIGH_FEEDBACK_TWO: hf2_q <= cfg_data_i;
          bbc_pkg::REG_LOW_GAIN:          lg_q  <= cfg_data_i;
          bbc_pkg::REG_LOW_FEEDBACK_ONE:  lf1_q <= cfg_data_i;
          bbc_pkg::REG_LOW_FEEDBACK_TWO:  lf2_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.take_sum) begin
        if (cmd_i.sec) begin
          ld2_q <= ld1_q;
          ld1_q <= w0_sat;
        end else begin
          hd2_q <= hd1_q;
          hd1_q <= w0_sat;
        end
      end
      prod_vld_q <= cmd_i.mul_en;
      if (cmd_i.load_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.mul_en) begin
      prod_q     <= mul_p;
      prod_hi_q  <= cmd_i.part_hi;
      prod_sub_q <= cmd_i.sub;
    end
    if (cmd_i.start) begin
      x_q    <= sample_in_i;
      clip_q <= 1'b0;
    end else if (cmd_i.take_sum) begin
      clip_q <= clip_q | w0_clip;
    end else if (cmd_i.take_y) begin
      clip_q <= clip_q | y_clip;
    end
    if (cmd_i.take_sum) begin
      sum_q <= sum_d;
    end
    if (cmd_i.take_y) begin
      h_q <= y_sat;
    end
    if (cmd_i.load_out) begin
      out_sample_q <= y_sat;
      out_clip_q   <= clip_q | y_clip;
    end
  end

  assign status_o.out_free = !out_vld_q || !out_stall_i;
  assign out_valid_o       = out_vld_q;
  assign sample_out_o      = out_sample_q;
  assign clipped_o         = out_clip_q;

endmodule

// File: rtl/bbc_ctrl.sv
// sequencer stepping the shared multiplier through both filter sections
module bbc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bbc_pkg::status_t status_i,
  output bbc_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FB1_HI,
    ST_FB2_LO,
    ST_FB2_HI,
    ST_FB_DRAIN,
    ST_SUM,
    ST_G_LO,
    ST_G_HI,
    ST_G_DRAIN,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   sec_q, sec_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    cmd_o.op_sel = bbc_pkg::OP_FB1_D1;
    cmd_o.sec    = sec_q;
    state_d = state_q;
    sec_d   = sec_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          sec_d       = 1'b0;
          state_d     = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load_acc = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.sub      = 1'b1;
        state_d        = ST_FB1_HI;
      end
      ST_FB1_HI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.part_hi = 1'b1;
        cmd_o.sub     = 1'b1;
        state_d       = ST_FB2_LO;
      end
      ST_FB2_LO: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op_sel = bbc_pkg::OP_FB2_D2;
        cmd_o.sub    = 1'b1;
        state_d      = ST_FB2_HI;
      end
      ST_FB2_HI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.op_sel  = bbc_pkg::OP_FB2_D2;
        cmd_o.part_hi = 1'b1;
        cmd_o.sub     = 1'b1;
        state_d       = ST_FB_DRAIN;
      end
      ST_FB_DRAIN: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.take_sum  = 1'b1;
        cmd_o.load_half = 1'b1;
        state_d         = ST_G_LO;
      end
      ST_G_LO: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op_sel = bbc_pkg::OP_GAIN_SUM;
        state_d      = ST_G_HI;
      end
      ST_G_HI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.op_sel  = bbc_pkg::OP_GAIN_SUM;
        cmd_o.part_hi = 1'b1;
        state_d       = ST_G_DRAIN;
      end
      ST_G_DRAIN: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!sec_q) begin
          cmd_o.take_y = 1'b1;
          sec_d        = 1'b1;
          state_d      = ST_LOAD;
        end else if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
    end
  end

endmodule

// File: rtl/biquad_bandpass_cascade.sv
// top level of the band-pass filter: highpass biquad then lowpass biquad
//
//   channel   direction  handshake                  payload
//   input     in         in_valid_i / in_stall_o    sample_in_i
//   output    out        out_valid_o / out_stall_i  sample_out_o, clipped_o
//   config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// each sample is worked through both sections by the single shared 32 x 22
// multiplier: 6 products per section, each delay or tap-sum operand split into
// two halves, plus load, drain and saturation steps; the next sample is taken
// only after the last one has gone to the output register
// input is taken only while the sequencer is idle; one finished result may sit
// in the output register while the next sample is accepted and worked on
// a stalled output holds the last section's result until the register frees
// asynchronous active-low reset clears coefficients, delay lines and control;
// the configuration port is always ready
module biquad_bandpass_cascade #(
  parameter int unsigned SAMPLE_BITS    = bbc_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = bbc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // sample input
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]           sample_in_i,
  // filtered output
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]           sample_out_o,
  output logic                                    clipped_o,
  // coefficient writes
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic        [bbc_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic signed [bbc_pkg::COEF_BITS-1:0]    cfg_data_i
);

  bbc_pkg::cmd_t    cmd;
  bbc_pkg::status_t status;

  // writes go straight into the coefficient registers, so the port never pushes back
  assign cfg_ready_o = 1'b1;

  // sequencer: one section after the other, highpass first
  bbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic, filter state and the output register
  bbc_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .sample_in_i  (sample_in_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o)
  );

endmodule

// File: bench/tb_top.sv
// self-checking bench for the highpass-then-lowpass biquad cascade
`timescale 1ns / 100ps

module tb_top;

  // block geometry, taken from the package defaults
  localparam int SB       = bbc_pkg::SAMPLE_BITS_DEF;
  localparam int F        = bbc_pkg::COEF_FRAC_BITS_DEF;
  localparam int DB       = bbc_pkg::DELAY_BITS;
  localparam int CB       = bbc_pkg::COEF_BITS;
  localparam int NUM_REGS = 6;

  // index codes past the end of the register file, writes there are dropped
  localparam logic [bbc_pkg::CFG_IDX_BITS-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [bbc_pkg::CFG_IDX_BITS-1:0] CFG_IDX_SPARE_HI = 3'd7;

  // middle numerator taps of the two sections
  localparam int HP_TAP = -2;
  localparam int LP_TAP = 2;

  // wide enough to hold every product sum exactly
  typedef logic signed [127:0] wide_t;

  localparam wide_t HALF     = wide_t'(1) <<< (F - 1);
  localparam wide_t DLY_MAX  = (wide_t'(1) <<< (DB - 1)) - 1;
  localparam wide_t DLY_MIN  = -DLY_MAX - 1;
  localparam wide_t SMP_HI_W = (wide_t'(1) <<< (SB - 1)) - 1;
  localparam wide_t SMP_LO_W = -SMP_HI_W - 1;

  localparam logic signed [CB-1:0] COEF_ONE = 32'sh1000_0000;
  localparam logic signed [CB-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CB-1:0] COEF_MIN = 32'sh8000_0000;
  localparam logic signed [SB-1:0] SMP_MAX  = 24'sh7F_FFFF;
  localparam logic signed [SB-1:0] SMP_MIN  = 24'sh80_0000;

  // random part shaping
  localparam int ONE_I           = 268435456;
  localparam int POLE_R          = 241591910; // 0.9 in Q3.28, keeps poles inside
  localparam int SMALL_AMP       = 65536;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 90;
  // quiet time after the last expected result
  localparam int DRAIN_CYCLES    = 50;
  localparam int TIMEOUT_NS      = 5_000_000;

  typedef struct packed {
    logic [SB-1:0] smp;
    logic          clip;
  } filt_res_t;

  typedef enum {ROW_CFG, ROW_SAMPLE, ROW_TYPED} row_kind_e;

  typedef struct {
    row_kind_e                        kind;
    logic [bbc_pkg::CFG_IDX_BITS-1:0] idx;
    logic signed [CB-1:0]             data;
    logic signed [SB-1:0]             smp;
    logic [SB-1:0]                    t_smp;
    logic                             t_clip;
  } stim_row_t;

  // dut ports, all known from time zero
  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_stall_o;
  logic signed [SB-1:0]             sample_in_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic signed [SB-1:0]             sample_out_o;
  logic                             clipped_o;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [bbc_pkg::CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic signed [CB-1:0]             cfg_data_i  = '0;

  // predictor state: coefficient bank and both delay lines
  logic signed [CB-1:0] coef [NUM_REGS];
  logic signed [DB-1:0] hp_d1 = '0;
  logic signed [DB-1:0] hp_d2 = '0;
  logic signed [DB-1:0] lp_d1 = '0;
  logic signed [DB-1:0] lp_d2 = '0;

  filt_res_t expected_out [$];
  stim_row_t plan [$];
  int        mismatch_count = 0;
  bit        idle_on = 1'b1;

  biquad_bandpass_cascade dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run-away guard
  initial begin
    #(TIMEOUT_NS);
    $display("tb_top NOT OK");
    $finish;
  end

  // one direct-form-II section: exact product sums, round half up, then saturate
  function automatic logic signed [SB-1:0] biquad_section(
    input wide_t                x,
    input logic signed [CB-1:0] gain,
    input logic signed [CB-1:0] fb1,
    input logic signed [CB-1:0] fb2,
    input int                   tap_mid,
    inout logic signed [DB-1:0] d1,
    inout logic signed [DB-1:0] d2,
    inout bit                   clip
  );
    wide_t w0;
    wide_t tap_sum;
    wide_t y;
    w0 = ((x <<< F) + HALF - wide_t'(fb1) * wide_t'(d1) - wide_t'(fb2) * wide_t'(d2)) >>> F;
    // delay overflow
    if (w0 > DLY_MAX) begin
      w0   = DLY_MAX;
      clip = 1'b1;
    end else if (w0 < DLY_MIN) begin
      w0   = DLY_MIN;
      clip = 1'b1;
    end
    tap_sum = w0 + wide_t'(tap_mid) * wide_t'(d1) + wide_t'(d2);
    y = (wide_t'(gain) * tap_sum + HALF) >>> F;
    // section output overflow
    if (y > SMP_HI_W) begin
      y    = SMP_HI_W;
      clip = 1'b1;
    end else if (y < SMP_LO_W) begin
      y    = SMP_LO_W;
      clip = 1'b1;
    end
    d2 = d1;
    d1 = w0[DB-1:0];
    return y[SB-1:0];
  endfunction

  // advances the predicted filter by one sample
  function automatic filt_res_t filter_sample(input logic signed [SB-1:0] x);
    bit                   clip;
    logic signed [SB-1:0] hp_y;
    logic signed [SB-1:0] lp_y;
    clip = 1'b0;
    hp_y = biquad_section(wide_t'(x), coef[bbc_pkg::REG_HIGH_GAIN],
                          coef[bbc_pkg::REG_HIGH_FEEDBACK_ONE],
                          coef[bbc_pkg::REG_HIGH_FEEDBACK_TWO],
                          HP_TAP, hp_d1, hp_d2, clip);
    lp_y = biquad_section(wide_t'(hp_y), coef[bbc_pkg::REG_LOW_GAIN],
                          coef[bbc_pkg::REG_LOW_FEEDBACK_ONE],
                          coef[bbc_pkg::REG_LOW_FEEDBACK_TWO],
                          LP_TAP, lp_d1, lp_d2, clip);
    return '{smp: lp_y, clip: clip};
  endfunction

  function automatic stim_row_t cfg_row(input logic [bbc_pkg::CFG_IDX_BITS-1:0] idx,
                                        input logic signed [CB-1:0] data);
    return '{kind: ROW_CFG, idx: idx, data: data, smp: '0, t_smp: '0, t_clip: 1'b0};
  endfunction

  function automatic stim_row_t smp_row(input logic signed [SB-1:0] smp);
    return '{kind: ROW_SAMPLE, idx: '0, data: '0, smp: smp, t_smp: '0, t_clip: 1'b0};
  endfunction

  function automatic stim_row_t typed_row(input logic signed [SB-1:0] smp,
                                          input logic [SB-1:0] t_smp, input logic t_clip);
    return '{kind: ROW_TYPED, idx: '0, data: '0, smp: smp, t_smp: t_smp, t_clip: t_clip};
  endfunction

  // mostly moderate audio, some full-scale noise and rail values
  function automatic logic signed [SB-1:0] random_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:          return r[0] ? SMP_MAX : SMP_MIN;
      1, 2, 3, 4: return r[SB-1:0];
      default:    return SB'(int'($urandom_range(0, 2 * SMALL_AMP)) - SMALL_AMP);
    endcase
  endfunction

  function automatic logic signed [CB-1:0] extreme_coef();
    case ($urandom_range(0, 4))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      2:       return '0;
      3:       return COEF_ONE;
      default: return -COEF_ONE;
    endcase
  endfunction

  // feedback pair with both poles inside the unit circle
  task automatic stable_pair(output logic signed [CB-1:0] fb1,
                             output logic signed [CB-1:0] fb2);
    int a2;
    int lim;
    a2  = int'($urandom_range(0, 2 * POLE_R)) - POLE_R;
    lim = ((ONE_I + a2) / 10) * 9;
    fb1 = int'($urandom_range(0, 2 * lim)) - lim;
    fb2 = a2;
  endtask

  // offers one sample, predicts on its transfer; returns at a falling edge
  task automatic push_sample(input logic signed [SB-1:0] smp, input bit typed,
                             input logic [SB-1:0] t_smp, input logic t_clip);
    filt_res_t pred;
    cfg_valid_i <= 1'b0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= smp;
    do @(posedge clk_i); while (in_stall_o);
    pred = filter_sample(smp);
    // typed rows still advance the predictor so later rows stay aligned
    if (typed)
      expected_out.push_back('{smp: t_smp, clip: t_clip});
    else
      expected_out.push_back(pred);
    @(negedge clk_i);
  endtask

  // one register transfer; valid is left high for a following write
  task automatic write_reg(input logic [bbc_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic signed [CB-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NUM_REGS)
      coef[idx] = data;
    @(negedge clk_i);
  endtask

  // coefficients only change once every sample in flight has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_out.size() != 0) @(negedge clk_i);
  endtask

  // output side: random stall bursts while idling is on
  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker: every output transfer against the oldest expectation
  always @(posedge clk_i) begin
    filt_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_out.size() == 0) begin
        $error("unexpected output transfer: sample_out %0d clipped %0b",
               sample_out_o, clipped_o);
        mismatch_count++;
      end else begin
        want = expected_out.pop_front();
        if (sample_out_o !== want.smp) begin
          $error("sample_out expected %0d actual %0d", $signed(want.smp), sample_out_o);
          mismatch_count++;
        end
        if (clipped_o !== want.clip) begin
          $error("clipped expected %0b actual %0b", want.clip, clipped_o);
          mismatch_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    logic signed [CB-1:0] bank [NUM_REGS];
    bit                   prev_cfg;

    foreach (coef[r]) coef[r] = '0;

    // directed table
    // writes past the register file must leave the zero bank untouched
    plan.push_back(cfg_row(CFG_IDX_SPARE_LO, COEF_MAX));
    plan.push_back(cfg_row(CFG_IDX_SPARE_HI, COEF_MIN));
    // zero gains after reset: silence whatever comes in
    plan.push_back(typed_row(SMP_MAX, '0, 1'b0));
    plan.push_back(typed_row(SMP_MIN, '0, 1'b0));
    plan.push_back(typed_row('0, '0, 1'b0));
    plan.push_back(typed_row(24'sd1, '0, 1'b0));
    plan.push_back(typed_row(-24'sd1, '0, 1'b0));
    // unity gains, rail-to-rail swing overflows the highpass
    plan.push_back(cfg_row(bbc_pkg::REG_HIGH_GAIN, COEF_ONE));
    plan.push_back(cfg_row(bbc_pkg::REG_LOW_GAIN, COEF_ONE));
    plan.push_back(smp_row(SMP_MAX));
    plan.push_back(smp_row(SMP_MIN));
    plan.push_back(smp_row(SMP_MAX));
    // largest gains, output saturation
    plan.push_back(cfg_row(bbc_pkg::REG_HIGH_GAIN, COEF_MAX));
    plan.push_back(cfg_row(bbc_pkg::REG_LOW_GAIN, COEF_MAX));
    plan.push_back(smp_row(SMP_MAX));
    plan.push_back(smp_row('0));
    // most negative gains
    plan.push_back(cfg_row(bbc_pkg::REG_HIGH_GAIN, COEF_MIN));
    plan.push_back(cfg_row(bbc_pkg::REG_LOW_GAIN, COEF_MIN));
    plan.push_back(smp_row(SMP_MIN));
    plan.push_back(smp_row(24'sd12345));
    // runaway feedback, the delay lines hit their 40-bit rails
    plan.push_back(cfg_row(bbc_pkg::REG_HIGH_FEEDBACK_ONE, COEF_MIN));
    plan.push_back(cfg_row(bbc_pkg::REG_HIGH_FEEDBACK_TWO, COEF_MAX));
    plan.push_back(cfg_row(bbc_pkg::REG_LOW_FEEDBACK_ONE, COEF_MAX));
    plan.push_back(cfg_row(bbc_pkg::REG_LOW_FEEDBACK_TWO, COEF_MIN));
    repeat (8) plan.push_back(smp_row(SMP_MAX));

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    prev_cfg = 1'b0;
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          if (!prev_cfg)
            settle();
          write_reg(plan[i].idx, plan[i].data);
        end
        ROW_SAMPLE: push_sample(plan[i].smp, 1'b0, '0, 1'b0);
        default:    push_sample(plan[i].smp, 1'b1, plan[i].t_smp, plan[i].t_clip);
      endcase
      prev_cfg = (plan[i].kind == ROW_CFG);
    end

    // random phases, each with its own coefficient set
    for (int p = 0; p < NUM_PHASES; p++) begin
      // one phase without idling mid-run, none at all in the final phase
      idle_on = (p != 3) && (p != NUM_PHASES - 1);
      if (p == 2 || p == 7) begin
        // raw bit patterns across the whole coefficient range
        foreach (bank[r]) bank[r] = $urandom;
      end else if (p == 5) begin
        foreach (bank[r]) bank[r] = extreme_coef();
      end else begin
        // realistic band-pass: stable poles, modest gains
        bank[bbc_pkg::REG_HIGH_GAIN] = int'($urandom_range(0, 2 * ONE_I)) - ONE_I;
        bank[bbc_pkg::REG_LOW_GAIN]  = $urandom_range(0, ONE_I / 4);
        stable_pair(bank[bbc_pkg::REG_HIGH_FEEDBACK_ONE],
                    bank[bbc_pkg::REG_HIGH_FEEDBACK_TWO]);
        stable_pair(bank[bbc_pkg::REG_LOW_FEEDBACK_ONE],
                    bank[bbc_pkg::REG_LOW_FEEDBACK_TWO]);
      end
      settle();
      // a stray write at any index first, the full bank then overrides it
      write_reg(bbc_pkg::CFG_IDX_BITS'($urandom_range(0, 7)), $urandom);
      for (int r = 0; r < NUM_REGS; r++)
        write_reg(bbc_pkg::CFG_IDX_BITS'(r), bank[r]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        push_sample(random_sample(), 1'b0, '0, 1'b0);
    end

    // drain, then give the block time to show any stray transfer
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    idle_on = 1'b0;
    while (expected_out.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0 && expected_out.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
